// ----- hw/rtl/dtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtb_pkg
// shared types and constants of the dominator tree builder
// ----------------------------------------------------------------------------
package dtb_pkg;

   localparam int MAX_NODES_DEF = 64;
   localparam int MAX_EDGES_DEF = 256;

   localparam int NODE_W  = 6;
   localparam int COUNT_W = 7;
   localparam int DOM_W   = 7;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 16;

   localparam logic [DOM_W-1:0] DOM_UNSET = 7'h7f;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_PASS_START,
      ST_NODE_START,
      ST_EDGE_RD,
      ST_EDGE_CHK,
      ST_SRC_CHK,
      ST_WALK,
      ST_WALK_UP,
      ST_NODE_END,
      ST_NODE_CMP,
      ST_PASS_END,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EMIT_HOLD
   } state_type;

endpackage

// ----- hw/rtl/dominator_tree_builder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dominator_tree_builder_top
// immediate dominators of a reverse-postorder numbered control-flow graph
// ----------------------------------------------------------------------------
// usage:
//   the req channel carries one predecessor edge per transfer, grouped by
//   ascending target; req_tlast marks the final transfer and carries the
//   node count. valid edges load one per cycle into the edge memory while idle.
//   after the final transfer the block clears the dominator memory, then runs
//   passes over nodes 1..count-1. each node scans the stored edges; for each
//   usable matching edge it intersects the candidate with the source by
//   walking both up their parent chains, then compares and updates the node's
//   entry. passes repeat until nothing changes, at most 2*MAX_NODES+2 times.
//   results follow on the rsp channel, one per node in ascending order; the
//   next result is read only after the current one is taken, and rsp_tlast
//   marks the last node.
//   req_tready is low from the final transfer until the last result is
//   taken. a stalled receiver simply holds the current result.
//   reset empties the edge store by clearing its count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dominator_tree_builder_top #(
   parameter int MAX_NODES = dtb_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = dtb_pkg::MAX_EDGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // node_count[6:0], edge_valid[7], target_node[13:8], source_node[19:14]
   input  logic [dtb_pkg::REQ_W-1:0] req_tdata,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // node[5:0], has_parent[6], parent[12:7]
   output logic [dtb_pkg::RSP_W-1:0] rsp_tdata,
   output logic                      rsp_tlast
);
   import dtb_pkg::*;

   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NAW = $clog2(MAX_NODES);
   localparam int MAX_PASSES = 2 * MAX_NODES + 2;
   localparam int PW = $clog2(MAX_PASSES + 1);
   localparam logic [EAW:0] EDGE_CAP = (EAW + 1)'(MAX_EDGES);
   localparam logic [COUNT_W-1:0] NODE_CAP = COUNT_W'(MAX_NODES);
   localparam logic [PW-1:0] PASS_CAP = PW'(MAX_PASSES);

   // memories
   logic [NODE_W-1:0] edge_src_mem [MAX_EDGES];
   logic [NODE_W-1:0] edge_tgt_mem [MAX_EDGES];
   logic [DOM_W-1:0]  dom_mem      [MAX_NODES];

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [EAW:0]       stored_ff, stored_in;
   logic [EAW:0]       e_ff, e_in;
   logic [NODE_W-1:0]  idx_ff, idx_in;
   logic [DOM_W-1:0]   np_ff, np_in;
   logic [NODE_W-1:0]  l_ff, l_in, r_ff, r_in;
   logic               side_ff, side_in;
   logic               changed_ff, changed_in;
   logic [PW-1:0]      pass_ff, pass_in;
   logic [COUNT_W-1:0] init_ff, init_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [NODE_W-1:0] src_q_ff, tgt_q_ff;
   logic [DOM_W-1:0]  dom_q_ff;
   logic              edge_we, dom_we;
   logic [EAW-1:0]    edge_waddr;
   logic [NAW-1:0]    dom_waddr, dom_raddr;
   logic [DOM_W-1:0]  dom_wdata;

   logic              req_fire;
   logic [COUNT_W-1:0] req_count, count_sat;
   logic [NODE_W-1:0] walk_x, walk_up;
   logic [DOM_W-1:0]  np_adj;
   logic [COUNT_W-1:0] idx_next;
   logic              has_par;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_count = req_tdata[6:0];
   assign count_sat = (req_count == '0) ? COUNT_W'(1) :
                      (req_count > NODE_CAP) ? NODE_CAP : req_count;
   assign walk_x  = side_ff ? r_ff : l_ff;
   assign walk_up = (dom_q_ff < {1'b0, walk_x}) ? dom_q_ff[NODE_W-1:0] : '0;
   assign np_adj  = (np_ff != DOM_UNSET && np_ff >= {1'b0, idx_ff}) ? '0 : np_ff;
   assign idx_next = {1'b0, idx_ff} + COUNT_W'(1);
   assign has_par = (idx_ff != '0) && (dom_q_ff != DOM_UNSET);
   assign edge_waddr = stored_ff[EAW-1:0];

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      stored_in    = stored_ff;
      e_in         = e_ff;
      idx_in       = idx_ff;
      np_in        = np_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      side_in      = side_ff;
      changed_in   = changed_ff;
      pass_in      = pass_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      edge_we      = 1'b0;
      dom_we       = 1'b0;
      dom_waddr    = '0;
      dom_wdata    = '0;
      dom_raddr    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tdata[7] && stored_ff < EDGE_CAP) begin
                  edge_we   = 1'b1;
                  stored_in = stored_ff + (EAW + 1)'(1);
               end
               if (req_tlast) begin
                  n_in     = count_sat;
                  init_in  = '0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            dom_we    = 1'b1;
            dom_waddr = init_ff[NAW-1:0];
            dom_wdata = (init_ff == '0) ? '0 : DOM_UNSET;
            init_in   = init_ff + COUNT_W'(1);
            if (init_ff == NODE_CAP - COUNT_W'(1)) begin
               pass_in  = '0;
               state_in = ST_PASS_START;
            end
         end
         ST_PASS_START: begin
            changed_in = 1'b0;
            if (n_ff <= COUNT_W'(1)) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               idx_in   = NODE_W'(1);
               state_in = ST_NODE_START;
            end
         end
         ST_NODE_START: begin
            np_in    = DOM_UNSET;
            e_in     = '0;
            state_in = ST_EDGE_RD;
         end
         ST_EDGE_RD: begin
            state_in = (e_ff < stored_ff) ? ST_EDGE_CHK : ST_NODE_END;
         end
         ST_EDGE_CHK: begin
            e_in = e_ff + (EAW + 1)'(1);
            if (tgt_q_ff == idx_ff && {1'b0, src_q_ff} < n_ff) begin
               dom_raddr = src_q_ff[NAW-1:0];
               state_in  = ST_SRC_CHK;
            end else begin
               state_in = ST_EDGE_RD;
            end
         end
         ST_SRC_CHK: begin
            if (dom_q_ff == DOM_UNSET) begin
               state_in = ST_EDGE_RD;
            end else if (np_ff == DOM_UNSET) begin
               np_in    = {1'b0, src_q_ff};
               state_in = ST_EDGE_RD;
            end else begin
               l_in     = np_ff[NODE_W-1:0];
               r_in     = src_q_ff;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (l_ff == r_ff) begin
               np_in    = {1'b0, l_ff};
               state_in = ST_EDGE_RD;
            end else if (l_ff > r_ff) begin
               side_in   = 1'b0;
               dom_raddr = l_ff[NAW-1:0];
               state_in  = ST_WALK_UP;
            end else begin
               side_in   = 1'b1;
               dom_raddr = r_ff[NAW-1:0];
               state_in  = ST_WALK_UP;
            end
         end
         ST_WALK_UP: begin
            if (side_ff) begin
               r_in = walk_up;
            end else begin
               l_in = walk_up;
            end
            state_in = ST_WALK;
         end
         ST_NODE_END: begin
            dom_raddr = idx_ff[NAW-1:0];
            state_in  = ST_NODE_CMP;
         end
         ST_NODE_CMP: begin
            if (np_adj != dom_q_ff) begin
               dom_we     = 1'b1;
               dom_waddr  = idx_ff[NAW-1:0];
               dom_wdata  = np_adj;
               changed_in = 1'b1;
            end
            if (idx_next < n_ff) begin
               idx_in   = idx_next[NODE_W-1:0];
               state_in = ST_NODE_START;
            end else begin
               state_in = ST_PASS_END;
            end
         end
         ST_PASS_END: begin
            pass_in = pass_ff + PW'(1);
            if (changed_ff && (pass_ff + PW'(1)) < PASS_CAP) begin
               state_in = ST_PASS_START;
            end else begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            dom_raddr = idx_ff[NAW-1:0];
            state_in  = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {3'b000, (has_par ? dom_q_ff[NODE_W-1:0] : NODE_W'(0)),
                            has_par, idx_ff};
            rsp_last_in  = (idx_next == n_ff);
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  stored_in = '0;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in   = idx_next[NODE_W-1:0];
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stored_ff    <= '0;
         n_ff         <= COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
         changed_ff   <= 1'b0;
         pass_ff      <= '0;
         init_ff      <= '0;
         e_ff         <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         changed_ff   <= changed_in;
         pass_ff      <= pass_in;
         init_ff      <= init_in;
         e_ff         <= e_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      np_ff       <= np_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      side_ff     <= side_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // edge memory
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_src_mem[edge_waddr] <= req_tdata[19:14];
         edge_tgt_mem[edge_waddr] <= req_tdata[13:8];
      end
      src_q_ff <= edge_src_mem[e_ff[EAW-1:0]];
      tgt_q_ff <= edge_tgt_mem[e_ff[EAW-1:0]];
   end

   // dominator memory
   always_ff @(posedge clock) begin
      if (dom_we) begin
         dom_mem[dom_waddr] <= dom_wdata;
      end
      dom_q_ff <= dom_mem[dom_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input open while a result is pending");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= EDGE_CAP)
      else $error("edge count beyond capacity");

   a_emit_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (stored_ff == '0 && req_tready))
      else $error("edge store not emptied after last result");

endmodule
